[sv/sslpg_pkg.sv]
// Shared constants and helpers for the servo slew limiter pulse generator.
// Holds request codes, register map and the angle-to-pulse scaling.
// No dependencies.
package sslpg_pkg;

  // Request kinds carried in tuser
  localparam logic [1:0] REQ_SET_POS = 2'd0;
  localparam logic [1:0] REQ_SET_TGT = 2'd1;
  localparam logic [1:0] REQ_TICK    = 2'd2;

  // Register map (word index)
  localparam logic [2:0] REG_OFFSET_CH0 = 3'd0;
  localparam logic [2:0] REG_OFFSET_CH1 = 3'd1;
  localparam logic [2:0] REG_OFFSET_CH2 = 3'd2;
  localparam logic [2:0] REG_OFFSET_CH3 = 3'd3;
  localparam logic [2:0] REG_POLARITY   = 3'd4;

  localparam int OFFSET_REGS      = 4;
  localparam int NUM_CHANNELS_DEF = 4;
  localparam int ADDR_W           = 5;
  localparam int DATA_W           = 32;

  localparam int PULSE_LOW  = 102;
  localparam int DEG_SPAN   = 180;
  localparam int DEG_CENTER = 90;

  // floor(deg*410/180) == (deg * 41 * ceil(2^21/18)) >> 21 for deg in 0..180
  localparam int          RECIP_SHIFT = 21;
  localparam logic [22:0] PULSE_MULT  = 23'd4776869;

  // Map a clamped angle in degrees to the PWM on-count
  function automatic logic [9:0] pulse_from_deg(input logic [7:0] deg);
    logic [30:0] prod;
    prod = 31'(deg) * 31'(PULSE_MULT);
    return 10'(PULSE_LOW) + 10'(prod[30:RECIP_SHIFT]);
  endfunction

endpackage

[sv/servo_slew_limiter_pulse_gen_core.sv]
// Top level of the multi-channel servo slew limiter and pulse generator.
// Depends on sslpg_pkg for request codes, register map and pulse scaling.
// Holds per-channel angle state, the APB register file and the result pipeline.

// Takes one request per cycle; stage 1 and output registers lie between acceptance
// and the pulse count. Each request names a channel and a kind (tuser): set position
// stores the angle as current and target and produces a pulse count, set target only
// stores the target, and tick steps the current angle one degree toward the target
// when they differ by more than one degree, producing a new count. Requests that
// change nothing visible produce no result. The channel state is updated in the cycle
// a request is accepted, so back-to-back requests to one channel see each other; the
// pulse count (102 + deg*410/180, deg clamped to 0..180) is computed in a second stage
// from the channel's offset and polarity registers. Throughput is one request per
// clock, limited only by out_tready. Registers must be written over APB only while
// the block is idle; the block itself does not enforce this.
module servo_slew_limiter_pulse_gen_core #(
  parameter int NUM_CHANNELS = sslpg_pkg::NUM_CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Request channel
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,   // [1:0] channel, [9:2] value, rest zero
  input  logic [1:0]                     in_tuser,   // [1:0] req_type
  // Result channel
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,  // [1:0] channel_out, [11:2] pulse_count
  // Register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sslpg_pkg::ADDR_W-1:0]   paddr,
  input  logic [sslpg_pkg::DATA_W-1:0]   pwdata,
  output logic [sslpg_pkg::DATA_W-1:0]   prdata,
  output logic                           pready
);
  import sslpg_pkg::*;

  localparam int STORE_D = (NUM_CHANNELS < OFFSET_REGS) ? NUM_CHANNELS : OFFSET_REGS;
  localparam int IDX_W   = (STORE_D > 1) ? $clog2(STORE_D) : 1;

  // Register file
  logic signed [7:0] offset_r [OFFSET_REGS];
  logic [3:0]        polarity_r;
  logic              reg_wr;
  logic [2:0]        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < OFFSET_REGS; i++) begin
        offset_r[i] <= '0;
      end
      polarity_r <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_OFFSET_CH0: offset_r[0] <= pwdata[7:0];
        REG_OFFSET_CH1: offset_r[1] <= pwdata[7:0];
        REG_OFFSET_CH2: offset_r[2] <= pwdata[7:0];
        REG_OFFSET_CH3: offset_r[3] <= pwdata[7:0];
        REG_POLARITY:   polarity_r  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_OFFSET_CH0: prdata = DATA_W'(unsigned'(offset_r[0]));
      REG_OFFSET_CH1: prdata = DATA_W'(unsigned'(offset_r[1]));
      REG_OFFSET_CH2: prdata = DATA_W'(unsigned'(offset_r[2]));
      REG_OFFSET_CH3: prdata = DATA_W'(unsigned'(offset_r[3]));
      REG_POLARITY:   prdata = DATA_W'(polarity_r);
      default:        prdata = '0;
    endcase
  end

  // Request fields
  logic [1:0]        req_type;
  logic [1:0]        req_ch;
  logic signed [7:0] req_val;
  logic [31:0]       ch_ext;
  logic [IDX_W-1:0]  ch_idx;
  logic              ch_ok;

  assign req_type = in_tuser;
  assign req_ch   = in_tdata[1:0];
  assign req_val  = in_tdata[9:2];
  assign ch_ext   = 32'(req_ch);
  assign ch_idx   = ch_ext[IDX_W-1:0];
  assign ch_ok    = ch_ext < 32'(NUM_CHANNELS);

  // Pipeline control
  logic s1_v_r, out_v_r;
  logic out_load, s1_load, in_acc;

  assign out_load   = !out_v_r || out_tready;
  assign s1_load    = !s1_v_r || out_load;
  assign in_tready  = s1_load;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_v_r;

  // Channel state update at acceptance
  logic signed [7:0] cur_r [STORE_D];
  logic signed [7:0] tgt_r [STORE_D];
  logic signed [7:0] cur_sel, tgt_sel, cur_nxt;
  logic signed [8:0] diff;
  logic              wr_cur, wr_tgt, emit;

  assign cur_sel = cur_r[ch_idx];
  assign tgt_sel = tgt_r[ch_idx];
  assign diff    = 9'(tgt_sel) - 9'(cur_sel);

  always_comb begin
    cur_nxt = cur_sel;
    wr_cur  = 1'b0;
    wr_tgt  = 1'b0;
    emit    = 1'b0;
    if (ch_ok) begin
      case (req_type)
        REQ_SET_POS: begin
          cur_nxt = req_val;
          wr_cur  = 1'b1;
          wr_tgt  = 1'b1;
          emit    = 1'b1;
        end
        REQ_SET_TGT: begin
          wr_tgt = 1'b1;
        end
        REQ_TICK: begin
          if (diff > 9'sd1) begin
            cur_nxt = cur_sel + 8'sd1;
            wr_cur  = 1'b1;
            emit    = 1'b1;
          end else if (diff < -9'sd1) begin
            cur_nxt = cur_sel - 8'sd1;
            wr_cur  = 1'b1;
            emit    = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_D; i++) begin
        cur_r[i] <= '0;
        tgt_r[i] <= '0;
      end
    end else if (in_acc) begin
      if (wr_cur) cur_r[ch_idx] <= cur_nxt;
      if (wr_tgt) tgt_r[ch_idx] <= req_val;
    end
  end

  // Stage 1: hold channel and new angle of an emitting request
  logic [1:0]        s1_ch_r;
  logic signed [7:0] s1_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_load) begin
      s1_v_r <= in_acc && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_acc) begin
      s1_ch_r  <= req_ch;
      s1_ang_r <= cur_nxt;
    end
  end

  // Stage 2: apply trim and polarity, clamp, scale to pulse count
  logic signed [7:0] s1_off;
  logic              s1_flip;
  logic signed [9:0] s1_deg;
  logic [7:0]        s1_deg_c;

  assign s1_off  = offset_r[s1_ch_r];
  assign s1_flip = polarity_r[s1_ch_r];

  always_comb begin
    s1_deg = 10'(DEG_CENTER) + 10'(s1_off) + (s1_flip ? -10'(s1_ang_r) : 10'(s1_ang_r));
    if (s1_deg < 10'sd0) begin
      s1_deg_c = '0;
    end else if (s1_deg > 10'(DEG_SPAN)) begin
      s1_deg_c = 8'(DEG_SPAN);
    end else begin
      s1_deg_c = s1_deg[7:0];
    end
  end

  logic [1:0] out_ch_r;
  logic [9:0] out_pulse_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_v_r) begin
      out_ch_r    <= s1_ch_r;
      out_pulse_r <= pulse_from_deg(s1_deg_c);
    end
  end

  assign out_tdata = {4'b0, out_pulse_r, out_ch_r};

endmodule

[bench/servo_slew_limiter_pulse_gen_core_tb.sv]
// Self-checking bench for servo_slew_limiter_pulse_gen_core: stream requests in, pulse counts out.
// Predicts each channel's angle ramp and pulse count, and changes registers over APB between phases.
// Depends on sslpg_pkg for request codes, the register map and the port widths.
`timescale 1ns / 1ps

module servo_slew_limiter_pulse_gen_core_tb;
  import sslpg_pkg::*;

  localparam int          NUM_CH     = NUM_CHANNELS_DEF;
  localparam logic [1:0]  REQ_UNUSED = 2'd3;
  localparam int          HOLD_OFF   = 300;

  typedef struct packed {
    logic [1:0] ch;
    logic [9:0] pulse;
  } pulse_t;

  // Channel angle model plus the queue of pulse counts still owed by the block
  class pulse_board;
    logic signed [7:0] cur_angle[NUM_CH];
    logic signed [7:0] tgt_angle[NUM_CH];
    logic signed [7:0] trim[NUM_CH];
    logic [3:0]        flip_mask;
    pulse_t            pending[$];
    int                errors;

    function new();
      for (int i = 0; i < NUM_CH; i++) begin
        cur_angle[i] = '0;
        tgt_angle[i] = '0;
        trim[i]      = '0;
      end
      flip_mask = '0;
      errors    = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [31:0] data);
      if (idx == REG_POLARITY) begin
        flip_mask = data[3:0];
      end else if (idx <= REG_OFFSET_CH3) begin
        trim[idx] = data[7:0];
      end
    endfunction

    // Scale the channel's trimmed, clamped angle to the PWM on-count
    function pulse_t count_for(logic [1:0] ch);
      pulse_t r;
      int     ang;
      int     deg;
      ang = cur_angle[ch];
      if (flip_mask[ch]) ang = -ang;
      deg = DEG_CENTER + int'(trim[ch]) + ang;
      if (deg < 0) deg = 0;
      if (deg > DEG_SPAN) deg = DEG_SPAN;
      r.ch    = ch;
      r.pulse = 10'(PULSE_LOW + (deg * 410) / DEG_SPAN);
      return r;
    endfunction

    // Advance the model on an accepted request; return 1 unless the block ignores it
    function bit note_request(logic [1:0] kind, logic [1:0] ch, logic signed [7:0] value);
      int gap;
      case (kind)
        REQ_SET_POS: begin
          cur_angle[ch] = value;
          tgt_angle[ch] = value;
          pending.push_back(count_for(ch));
          return 1'b1;
        end
        REQ_SET_TGT: begin
          tgt_angle[ch] = value;
          return 1'b1;
        end
        REQ_TICK: begin
          gap = int'(tgt_angle[ch]) - int'(cur_angle[ch]);
          if (gap >= -1 && gap <= 1) return 1'b0;
          cur_angle[ch] = cur_angle[ch] + ((gap > 0) ? 8'sd1 : -8'sd1);
          pending.push_back(count_for(ch));
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    function void check_result(logic [1:0] ch, logic [9:0] pulse);
      pulse_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: channel_out %0d, pulse_count %0d", ch, pulse);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (ch !== want.ch) begin
        $error("channel_out: expected %0d, got %0d", want.ch, ch);
        errors++;
      end
      if (pulse !== want.pulse) begin
        $error("pulse_count: expected %0d, got %0d", want.pulse, pulse);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [1:0] channel, [9:2] value, rest zero
  logic [1:0]  in_tuser = '0;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [1:0] channel_out, [11:2] pulse_count
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic        pready;

  pulse_board sb = new();
  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int hold_off_seq      = 0;
  int hold_seen         = 0;
  int hold_left         = 0;
  int live_items        = 0;

  servo_slew_limiter_pulse_gen_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: long hold-off on request, else random stalls
  always @(posedge clk) begin
    if (hold_off_seq != hold_seen) begin
      hold_seen  <= hold_off_seq;
      hold_left  <= HOLD_OFF;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Check results first, then note the request accepted at the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata[1:0], out_tdata[11:2]);
      if (in_tvalid && in_tready) begin
        if (sb.note_request(in_tuser, in_tdata[1:0], in_tdata[9:2])) live_items++;
      end
    end
  end

  // Offer one request, idling first at random; valid stays high after the handshake
  task automatic send_request(input logic [1:0] kind, input logic [1:0] ch,
                              input logic [7:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {6'b0, value, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop offering, let the last request be noted, then wait out every owed result
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_angle();
    if ($urandom_range(9) == 0) return 8'($urandom);
    return 8'($urandom_range(180) - 90);
  endfunction

  // Mostly target moves followed by ramp ticks, with some jumps and noise
  task automatic random_request();
    int r;
    r = $urandom_range(99);
    if (r < 8) send_request(REQ_SET_POS, 2'($urandom_range(3)), pick_angle());
    else if (r < 22) send_request(REQ_SET_TGT, 2'($urandom_range(3)), pick_angle());
    else if (r < 27) send_request(REQ_UNUSED, 2'($urandom_range(3)), 8'($urandom));
    else send_request(REQ_TICK, 2'($urandom_range(3)), 8'($urandom));
  endtask

  initial begin
    logic signed [7:0] trims[NUM_CH];
    logic [3:0]        mask;
    int                goal;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: begin
          trims = '{8'sd0, 8'sd0, 8'sd0, 8'sd0};
          mask  = 4'b0000;
        end
        1: begin
          trims = '{8'sd90, -8'sd90, 8'sd45, -8'sd45};
          mask  = 4'b1010;
        end
        2: begin
          trims = '{-8'sd90, 8'sd90, 8'sd0, -8'sd1};
          mask  = 4'b1111;
        end
        default: begin
          for (int i = 0; i < NUM_CH; i++) trims[i] = 8'($urandom_range(180) - 90);
          mask = 4'($urandom);
        end
      endcase
      for (int i = 0; i < NUM_CH; i++) write_register(3'(i), 32'(signed'(trims[i])));
      write_register(REG_POLARITY, 32'(mask));

      // Idle mix: sender light / receiver heavy, then swapped, then none
      case (phase)
        0, 1: begin
          sender_idle_pct   = 33;
          receiver_idle_pct <= 86;
        end
        2: begin
          sender_idle_pct   = 86;
          receiver_idle_pct <= 33;
        end
        default: begin
          sender_idle_pct   = 0;
          receiver_idle_pct <= 0;
        end
      endcase

      if (phase == 0) begin
        // Extremes and clamping at both ends
        send_request(REQ_SET_POS, 2'd0, 8'sd90);
        send_request(REQ_SET_POS, 2'd0, -8'sd90);
        send_request(REQ_SET_POS, 2'd0, 8'sd127);
        send_request(REQ_SET_POS, 2'd0, -8'sd128);
        send_request(REQ_SET_POS, 2'd1, 8'sd0);
        // Target only, then ramp toward it
        send_request(REQ_SET_TGT, 2'd2, 8'sd5);
        send_request(REQ_TICK, 2'd2, 8'hFF);
        send_request(REQ_TICK, 2'd2, 8'h00);
        // Ticks with no movement: equal and one degree apart
        send_request(REQ_TICK, 2'd3, 8'h00);
        send_request(REQ_SET_TGT, 2'd3, 8'sd1);
        send_request(REQ_TICK, 2'd3, 8'h00);
        // Ramp down until within one degree
        send_request(REQ_SET_TGT, 2'd3, -8'sd4);
        repeat (4) send_request(REQ_TICK, 2'd3, 8'h00);
        // Unused request kind with every bit set
        send_request(REQ_UNUSED, 2'd3, 8'hFF);
        send_request(REQ_SET_POS, 2'd3, 8'sd45);
      end else begin
        if (phase == 3) begin
          // Hold the receiver off while requests keep coming, so the block backs up
          hold_off_seq <= hold_off_seq + 1;
          for (int i = 0; i < 40; i++)
            send_request(REQ_SET_POS, 2'($urandom_range(3)), pick_angle());
        end
        goal = live_items + 100;
        while (live_items < goal) random_request();
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("servo_slew_limiter_pulse_gen_core regression: pass");
    end else begin
      $display("servo_slew_limiter_pulse_gen_core regression: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("servo_slew_limiter_pulse_gen_core regression: fail");
    $finish;
  end

endmodule

[servo_slew_limiter_pulse_gen_core.f]
sv/sslpg_pkg.sv
sv/servo_slew_limiter_pulse_gen_core.sv
bench/servo_slew_limiter_pulse_gen_core_tb.sv
